FILE: sv/php2_pkg.sv
// Shared types and constants for the proxy v2 header parser.
// No dependencies; php2_parse, php2_out_reg and the top level use it.
package php2_pkg;

    localparam int unsigned SIG_LEN = 12;

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D,
        8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A
    };

    localparam logic [15:0] HDR_VER_IDX  = 16'd12;
    localparam logic [15:0] HDR_FAM_IDX  = 16'd13;
    localparam logic [15:0] HDR_LENH_IDX = 16'd14;

    localparam logic [15:0] MAX_BODY_LEN_RST = 16'd4096;
    localparam logic [15:0] MIN_BODY_LEN     = 16'd12;
    localparam logic [15:0] MIN_IPV6_LEN     = 16'd36;

    localparam logic [3:0] VERSION_2  = 4'h2;
    localparam logic [3:0] CMD_PROXY  = 4'h1;
    localparam logic [7:0] FAM_IPV4   = 8'd1;
    localparam logic [7:0] FAM_IPV6   = 8'd2;

    // IPv4 block: src addr, dst addr, ports
    localparam logic [15:0] V4_SRC_END  = 16'd4;
    localparam logic [15:0] V4_DST_END  = 16'd8;
    localparam logic [15:0] V4_PORT_END = 16'd12;
    // IPv6 block
    localparam logic [15:0] V6_SRCH_END = 16'd8;
    localparam logic [15:0] V6_SRCL_END = 16'd16;
    localparam logic [15:0] V6_DSTH_END = 16'd24;
    localparam logic [15:0] V6_DSTL_END = 16'd32;
    localparam logic [15:0] V6_PORT_END = 16'd36;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIG    = 3'd1;
    localparam logic [2:0] ST_BAD_LEN    = 3'd2;
    localparam logic [2:0] ST_BAD_VER    = 3'd3;
    localparam logic [2:0] ST_BAD_CMD    = 3'd4;
    localparam logic [2:0] ST_BAD_FAMILY = 3'd5;
    localparam logic [2:0] ST_CLOSED     = 3'd6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        first;
    } php2_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        family;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } php2_result_t;

endpackage

FILE: sv/php2_ifs.sv
// Channel interfaces of the proxy v2 header parser: byte input, result
// output and configuration write. Depends on nothing.
interface php2_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output kind, output data_byte, output first, input ready);
    modport sink   (input valid, input kind, input data_byte, input first, output ready);
endinterface

interface php2_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        family;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;

    modport source (
        output valid, output status, output family,
        output src_addr_hi, output src_addr_lo, output dst_addr_hi, output dst_addr_lo,
        output src_port, output dst_port,
        input  ready
    );
    modport sink (
        input  valid, input status, input family,
        input  src_addr_hi, input src_addr_lo, input dst_addr_hi, input dst_addr_lo,
        input  src_port, input dst_port,
        output ready
    );
endinterface

interface php2_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_body_len;

    modport source (output valid, output max_body_len, input ready);
    modport sink   (input valid, input max_body_len, output ready);
endinterface

FILE: sv/php2_parse.sv
// Header parse state and per-beat next-state / result logic.
// Depends on php2_pkg.
module php2_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  php2_pkg::php2_beat_t  beat,
    input  logic [15:0]           max_body_len,
    output logic                  res_valid,
    output php2_pkg::php2_result_t res
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [15:0] count_reg,   count_next;
    logic        sig_ok_reg,  sig_ok_next;
    logic [7:0]  vc_reg,      vc_next;
    logic [7:0]  fam_reg,     fam_next;
    logic [15:0] len_reg,     len_next;
    logic [63:0] src_hi_reg,  src_hi_next;
    logic [63:0] src_lo_reg,  src_lo_next;
    logic [63:0] dst_hi_reg,  dst_hi_next;
    logic [63:0] dst_lo_reg,  dst_lo_next;
    logic [31:0] port_reg,    port_next;

    phase_t      cur_phase;
    logic [15:0] cur_count;
    logic        cur_sig_ok;
    logic [15:0] full_len;
    logic        body_last;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sig_ok_next = sig_ok_reg;
        vc_next     = vc_reg;
        fam_next    = fam_reg;
        len_next    = len_reg;
        src_hi_next = src_hi_reg;
        src_lo_next = src_lo_reg;
        dst_hi_next = dst_hi_reg;
        dst_lo_next = dst_lo_reg;
        port_next   = port_reg;
        res_valid   = 1'b0;
        res         = '0;
        cur_phase   = beat.first ? PH_HEADER : phase_reg;
        cur_count   = beat.first ? 16'd0 : count_reg;
        cur_sig_ok  = beat.first ? 1'b1 : sig_ok_reg;
        full_len    = {len_reg[15:8], beat.data_byte};
        body_last   = ({1'b0, count_reg} + 17'd1) >= {1'b0, len_reg};

        if (step)
        begin
            if (beat.kind)
            begin
                if (phase_reg == PH_HEADER || phase_reg == PH_BODY)
                begin
                    res_valid   = 1'b1;
                    res.status  = php2_pkg::ST_CLOSED;
                    phase_next  = PH_DONE;
                end
            end
            else
            begin
                if (beat.first)
                begin
                    phase_next  = PH_HEADER;
                    count_next  = '0;
                    sig_ok_next = 1'b1;
                    vc_next     = '0;
                    fam_next    = '0;
                    len_next    = '0;
                    src_hi_next = '0;
                    src_lo_next = '0;
                    dst_hi_next = '0;
                    dst_lo_next = '0;
                    port_next   = '0;
                end
                case (cur_phase)
                    PH_HEADER:
                    begin
                        if (cur_count < 16'(php2_pkg::SIG_LEN))
                        begin
                            if (beat.data_byte != php2_pkg::SIG_BYTES[cur_count[3:0]])
                            begin
                                sig_ok_next = 1'b0;
                            end
                            count_next = cur_count + 16'd1;
                        end
                        else if (cur_count == php2_pkg::HDR_VER_IDX)
                        begin
                            vc_next    = beat.data_byte;
                            count_next = cur_count + 16'd1;
                        end
                        else if (cur_count == php2_pkg::HDR_FAM_IDX)
                        begin
                            fam_next   = beat.data_byte;
                            count_next = cur_count + 16'd1;
                        end
                        else if (cur_count == php2_pkg::HDR_LENH_IDX)
                        begin
                            len_next   = {beat.data_byte, 8'h00};
                            count_next = cur_count + 16'd1;
                        end
                        else
                        begin
                            len_next = full_len;
                            if (!cur_sig_ok)
                            begin
                                res_valid  = 1'b1;
                                res.status = php2_pkg::ST_BAD_SIG;
                                phase_next = PH_DONE;
                            end
                            else if (full_len > max_body_len
                                     || full_len < php2_pkg::MIN_BODY_LEN)
                            begin
                                res_valid  = 1'b1;
                                res.status = php2_pkg::ST_BAD_LEN;
                                phase_next = PH_DONE;
                            end
                            else if (vc_reg[7:4] != php2_pkg::VERSION_2)
                            begin
                                res_valid  = 1'b1;
                                res.status = php2_pkg::ST_BAD_VER;
                                phase_next = PH_DONE;
                            end
                            else if (vc_reg[3:0] != php2_pkg::CMD_PROXY)
                            begin
                                res_valid  = 1'b1;
                                res.status = php2_pkg::ST_BAD_CMD;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                                count_next = '0;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (fam_reg == php2_pkg::FAM_IPV4)
                        begin
                            if (count_reg < php2_pkg::V4_SRC_END)
                                src_lo_next = {src_lo_reg[55:0], beat.data_byte};
                            else if (count_reg < php2_pkg::V4_DST_END)
                                dst_lo_next = {dst_lo_reg[55:0], beat.data_byte};
                            else if (count_reg < php2_pkg::V4_PORT_END)
                                port_next = {port_reg[23:0], beat.data_byte};
                        end
                        else if (fam_reg == php2_pkg::FAM_IPV6)
                        begin
                            if (count_reg < php2_pkg::V6_SRCH_END)
                                src_hi_next = {src_hi_reg[55:0], beat.data_byte};
                            else if (count_reg < php2_pkg::V6_SRCL_END)
                                src_lo_next = {src_lo_reg[55:0], beat.data_byte};
                            else if (count_reg < php2_pkg::V6_DSTH_END)
                                dst_hi_next = {dst_hi_reg[55:0], beat.data_byte};
                            else if (count_reg < php2_pkg::V6_DSTL_END)
                                dst_lo_next = {dst_lo_reg[55:0], beat.data_byte};
                            else if (count_reg < php2_pkg::V6_PORT_END)
                                port_next = {port_reg[23:0], beat.data_byte};
                        end

                        if (body_last)
                        begin
                            res_valid  = 1'b1;
                            phase_next = PH_DONE;
                            if (fam_reg == php2_pkg::FAM_IPV4
                                || (fam_reg == php2_pkg::FAM_IPV6
                                    && len_reg >= php2_pkg::MIN_IPV6_LEN))
                            begin
                                res.status      = php2_pkg::ST_OK;
                                res.family      = (fam_reg == php2_pkg::FAM_IPV6);
                                res.src_addr_hi = src_hi_next;
                                res.src_addr_lo = src_lo_next;
                                res.dst_addr_hi = dst_hi_next;
                                res.dst_addr_lo = dst_lo_next;
                                res.src_port    = port_next[31:16];
                                res.dst_port    = port_next[15:0];
                            end
                            else if (fam_reg == php2_pkg::FAM_IPV6)
                            begin
                                res.status = php2_pkg::ST_BAD_LEN;
                            end
                            else
                            begin
                                res.status = php2_pkg::ST_BAD_FAMILY;
                            end
                        end
                        else
                        begin
                            count_next = count_reg + 16'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            sig_ok_reg <= 1'b1;
            vc_reg     <= '0;
            fam_reg    <= '0;
            len_reg    <= '0;
            src_hi_reg <= '0;
            src_lo_reg <= '0;
            dst_hi_reg <= '0;
            dst_lo_reg <= '0;
            port_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sig_ok_reg <= sig_ok_next;
            vc_reg     <= vc_next;
            fam_reg    <= fam_next;
            len_reg    <= len_next;
            src_hi_reg <= src_hi_next;
            src_lo_reg <= src_lo_next;
            dst_hi_reg <= dst_hi_next;
            dst_lo_reg <= dst_lo_next;
            port_reg   <= port_next;
        end
    end

endmodule

FILE: sv/php2_out_reg.sv
// Result register of the proxy v2 header parser; drives the result channel.
// Depends on php2_pkg and php2_ifs.
module php2_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   res_valid,
    input  php2_pkg::php2_result_t res,
    output logic                   free,
    php2_out_if.source             result
);

    logic                   valid_reg;
    php2_pkg::php2_result_t data_reg;

    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= step && res_valid;
        end
    end

    // hold payload while the beat waits
    always_ff @(posedge clk)
    begin
        if (free && step && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign result.valid       = valid_reg;
    assign result.status      = data_reg.status;
    assign result.family      = data_reg.family;
    assign result.src_addr_hi = data_reg.src_addr_hi;
    assign result.src_addr_lo = data_reg.src_addr_lo;
    assign result.dst_addr_hi = data_reg.dst_addr_hi;
    assign result.dst_addr_lo = data_reg.dst_addr_lo;
    assign result.src_port    = data_reg.src_port;
    assign result.dst_port    = data_reg.dst_port;

endmodule

FILE: sv/proxy_v2_header_parser.sv
// Top level of the proxy v2 header parser: input register, parse core,
// result register, max_body_len register. Depends on php2_pkg, php2_ifs,
// php2_parse and php2_out_reg.
//
// Usage:
//   byte_in  - one beat per received byte (kind 0) or per close event (kind 1);
//              first marks the opening byte of a header and restarts parsing.
//   result   - at most one status beat per header: ok with captured
//              addresses and ports, a check failure, or closed.
//   cfg      - write of max_body_len; always ready. Write only while idle.
// Path: an accepted beat waits in the input register, is parsed by the parse
//   step once the result register is free, and its result, if any, is loaded
//   into the result register. Throughput: one beat per cycle while no result
//   stalls, set by the single parse step between the input and result registers.
// Reset: parser goes idle, max_body_len returns to 4096, both registers empty.
// Stall: while a result waits unaccepted, the input register holds one more
//   beat and byte_in.ready drops until the result is taken.
module proxy_v2_header_parser (
    input  logic      clk,
    input  logic      rst_n,
    php2_in_if.sink   byte_in,
    php2_out_if.source result,
    php2_cfg_if.sink  cfg
);

    logic                   in_valid_reg;
    php2_pkg::php2_beat_t   beat_reg;
    logic [15:0]            max_len_reg;
    logic                   free;
    logic                   step;
    logic                   res_valid;
    php2_pkg::php2_result_t res;

    assign step          = in_valid_reg && free;
    assign byte_in.ready = !in_valid_reg || free;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= php2_pkg::MAX_BODY_LEN_RST;
        end
        else
        begin
            if (byte_in.ready)
            begin
                in_valid_reg <= byte_in.valid;
            end
            if (cfg.valid)
            begin
                max_len_reg <= cfg.max_body_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            beat_reg.kind      <= byte_in.kind;
            beat_reg.data_byte <= byte_in.data_byte;
            beat_reg.first     <= byte_in.first;
        end
    end

    php2_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .beat         (beat_reg),
        .max_body_len (max_len_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    php2_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .result    (result)
    );

endmodule

FILE: sv/php2_checker.sv
// Port-level checks of the proxy v2 header parser, bound to the top level.
// Depends on the top level's ports only.
module php2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        family,
    input logic [63:0] src_addr_hi,
    input logic [63:0] src_addr_lo,
    input logic [63:0] dst_addr_hi,
    input logic [63:0] dst_addr_lo,
    input logic [15:0] src_port,
    input logic [15:0] dst_port
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(src_port))
        else $error("result beat changed while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 3'd0 |-> !family && src_addr_hi == 64'd0
            && src_addr_lo == 64'd0 && dst_addr_hi == 64'd0 && dst_addr_lo == 64'd0
            && src_port == 16'd0 && dst_port == 16'd0)
        else $error("failed header carries address data");

    a_ipv4_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 3'd0 && !family |-> src_addr_hi == 64'd0
            && dst_addr_hi == 64'd0 && src_addr_lo[63:32] == 32'd0
            && dst_addr_lo[63:32] == 32'd0)
        else $error("IPv4 result has upper address bits set");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 3'd7)
        else $error("undefined status code");

endmodule

bind proxy_v2_header_parser php2_checker u_php2_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .status      (result.status),
    .family      (result.family),
    .src_addr_hi (result.src_addr_hi),
    .src_addr_lo (result.src_addr_lo),
    .dst_addr_hi (result.dst_addr_hi),
    .dst_addr_lo (result.dst_addr_lo),
    .src_port    (result.src_port),
    .dst_port    (result.dst_port)
);
